>>> rtl/rfde_pkg.sv
// Package with types and constants shared by the frame difference encoder modules.
`timescale 1ns / 1ps
package rfde_pkg;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	localparam logic CMD_COMPARE = 1'b0;
	localparam logic CMD_LOAD    = 1'b1;

	localparam logic [12:0] MAX_SIZE = 13'd4096;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic capture;     // latch the accepted request
		logic rd_take;     // registered read data is valid this cycle
		logic consume;     // advance the read index and add the run to the gap
		logic finish;      // complete the word: compare, totals, store, position
		logic out_take;    // result register was taken downstream
	} rfde_cmd_t;

	// Status returned from the datapath to the controller.
	typedef struct packed {
		logic is_load;     // captured request is a load command
		logic fast_path;   // gap is zero before any read: an equal read decides the word
		logic gap_ahead;   // gap is above zero before any read: peek only
		logic gap_pos;     // gap after the last consumed run is above zero
		logic eq_word;     // registered reference word equals the new word
	} rfde_stat_t;

	function automatic logic [12:0] clamp_size(input logic [12:0] v);
		if (v == 13'd0) return 13'd1;
		if (v > MAX_SIZE) return MAX_SIZE;
		return v;
	endfunction

	function automatic logic [8:0] run_of(input logic [7:0] c);
		return (c == 8'd0) ? 9'd1 : {1'b0, c};
	endfunction

endpackage

>>> rtl/rfde_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module rfde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/rfde_ctrl.sv
// Controller state machine sequencing reference reads and result delivery.
`timescale 1ns / 1ps
module rfde_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                out_busy,
	input  logic                m_tready,
	input  rfde_pkg::rfde_stat_t stat,
	output rfde_pkg::rfde_cmd_t  cmd
);
	import rfde_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_free;

	// The result register is free when empty or being taken this cycle.
	assign out_free     = !out_busy || m_tready;
	assign s_tready     = (state_q == ST_IDLE);
	assign cmd.capture  = s_tready && s_tvalid;
	assign cmd.rd_take  = (state_q == ST_DECIDE);
	assign cmd.consume  = (state_q == ST_DECIDE) && !(stat.fast_path && stat.eq_word)
		&& !stat.gap_ahead;
	assign cmd.finish   = (state_q == ST_FINISH) && out_free;
	assign cmd.out_take = out_busy && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= stat.is_load ? ST_FINISH : ST_WAIT;
				end
				ST_WAIT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// Equal aligned word, a gap already ahead, or a positive gap
					// after a consumed run ends the walk.
					if ((stat.fast_path && stat.eq_word) || stat.gap_ahead || stat.gap_pos) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A read is issued again each time the walk loops back to wait.
	// (ST_WAIT follows ST_DECIDE with the index already advanced.)

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> out_free)
		else $error("finish with result register occupied");
	a_capture_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_READ)
		else $error("capture not followed by read");

endmodule

>>> rtl/rfde_dpath.sv
// Datapath: reference memory, run walk, position, totals and result register.
`timescale 1ns / 1ps
module rfde_dpath #(
	parameter int REF_WORDS    = 65536,
	parameter int HEADER_BYTES = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rfde_pkg::rfde_cmd_t  cmd,
	output rfde_pkg::rfde_stat_t stat,
	input  logic                 in_cmd,
	input  logic [31:0]          in_word,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [12:0]          cfg_data,
	output logic                 out_busy,
	output logic [115:0]         out_data
);
	import rfde_pkg::*;

	localparam int IW = $clog2(REF_WORDS);

	// Bank indices wrap at REF_WORDS, also when it is not a power of two.
	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		return (i == IW'(REF_WORDS - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [12:0] width_q, height_q;
	logic        cmd_q;
	logic [31:0] word_q;
	logic        bank_q;
	logic [IW-1:0] rd_idx_q, wr_idx_q;
	logic signed [10:0] gap_q;
	logic        store_q;
	logic [11:0] row_q;
	logic [12:0] col_q;
	logic [23:0] blocks_q;
	logic [31:0] bytes_q;
	logic        zero_q;
	logic [31:0] left_q;
	logic        walked_q;
	logic [8:0]  adv_q;

	logic        we;
	logic [IW:0] addr;
	logic [31:0] rdata;
	logic [8:0]  rd_run, wc;

	assign we   = cmd.finish;
	assign addr = we ? {~bank_q, wr_idx_q} : {bank_q, rd_idx_q};

	rfde_ram #(.WIDTH(32), .DEPTH(2 << IW)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(word_q), .rdata(rdata)
	);

	assign rd_run         = run_of(rdata[7:0]);
	assign wc             = run_of(word_q[7:0]);
	assign stat.is_load   = (cmd_q == CMD_LOAD);
	assign stat.fast_path = (gap_q == 11'sd0) && !walked_q;
	assign stat.gap_ahead = (gap_q > 11'sd0) && !walked_q;
	assign stat.eq_word   = (rdata == word_q);
	assign stat.gap_pos   = (gap_q + $signed({2'b0, rd_run})) > 11'sd0;

	// Finish-stage values.
	logic         chg, opn;
	logic signed [10:0] gap_n;
	logic [13:0]  col_n;
	logic [12:0]  wdt, hgt;
	logic         row_end, frm_end;
	logic [23:0]  blocks_n;
	logic [32:0]  bsum;
	logic [31:0]  bytes_n;

	always_comb begin
		wdt   = clamp_size(width_q);
		hgt   = clamp_size(height_q);
		chg   = 1'b0;
		opn   = 1'b0;
		gap_n = gap_q;
		if (cmd_q == CMD_COMPARE && walked_q) begin
			gap_n = gap_q - $signed({2'b0, wc});
			chg   = (gap_n != 11'sd0) || (left_q != word_q);
			opn   = chg && !store_q;
		end
		blocks_n = blocks_q;
		bsum     = {1'b0, bytes_q};
		if (chg) begin
			bsum = {1'b0, bytes_q} + 33'd4;
			if (opn) begin
				if (blocks_q != 24'hffffff) blocks_n = blocks_q + 24'd1;
				bsum = bsum + 33'(HEADER_BYTES);
			end
		end
		bytes_n = bsum[32] ? 32'hffffffff : bsum[31:0];
		col_n   = {1'b0, col_q} + {5'b0, adv_q};
		row_end = col_n >= {1'b0, wdt};
		frm_end = row_end && ({1'b0, row_q} + 13'd1 >= hgt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1920;
			height_q <= 13'd1080;
			bank_q   <= 1'b0;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			gap_q    <= '0;
			store_q  <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			blocks_q <= '0;
			bytes_q  <= '0;
			out_busy <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FRAME_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (cmd.finish) begin
				out_busy <= 1'b1;
			end else if (cmd.out_take) begin
				out_busy <= 1'b0;
			end
			if (cmd.rd_take && stat.fast_path && stat.eq_word) begin
				rd_idx_q <= next_idx(rd_idx_q);
				store_q  <= 1'b0;
			end else if (cmd.consume) begin
				rd_idx_q <= next_idx(rd_idx_q);
				gap_q    <= gap_q + $signed({2'b0, rd_run});
			end
			if (cmd.finish) begin
				if (frm_end) begin
					row_q    <= '0;
					bank_q   <= ~bank_q;
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					blocks_q <= '0;
					bytes_q  <= '0;
				end else begin
					wr_idx_q <= next_idx(wr_idx_q);
					blocks_q <= blocks_n;
					bytes_q  <= bytes_n;
					if (row_end) row_q <= row_q + 12'd1;
				end
				if (row_end) begin
					col_q   <= '0;
					gap_q   <= '0;
					store_q <= 1'b0;
				end else begin
					col_q <= col_n[12:0];
					if (cmd_q == CMD_COMPARE && walked_q) begin
						gap_q   <= gap_n;
						store_q <= chg;
					end
				end
			end
		end
	end

	// Payload of the current request; walk flags.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= in_cmd;
			word_q   <= in_word;
			zero_q   <= (in_word[7:0] == 8'd0);
			walked_q <= 1'b0;
			adv_q    <= run_of(in_word[7:0]);
			left_q   <= '0;
		end
		if (cmd.rd_take) begin
			left_q <= rdata;
			// A peek with the gap already ahead does not count the run.
			if (!stat.gap_ahead && rdata[7:0] == 8'd0) zero_q <= 1'b1;
			if (stat.fast_path && stat.eq_word) begin
				adv_q <= rd_run;
			end else begin
				walked_q <= 1'b1;
			end
		end
		if (cmd.finish) begin
			out_data <= {zero_q, frm_end, bytes_n, blocks_n, word_q,
				col_q[11:0], row_q, opn, chg};
		end
	end

endmodule

>>> rtl/rle_frame_difference_encoder.sv
// Top level of the run-length frame difference encoder.
`timescale 1ns / 1ps
// Each request carries one run-length word (color in bits 31..8, count in
// bits 7..0) and a command bit. A compare request walks the stored reference
// runs of the active bank until the run streams line up, and the result
// reports whether the word changed, whether it opens a new block, its row and
// column, and saturating block and byte totals; m_tlast marks the result of
// the word that completes a frame. Every word is written into the other bank,
// and the banks swap when a frame completes. One request is in flight at a
// time. A load request goes from acceptance through the read and finish
// states before the next request can be accepted. A compare request goes
// through the read state, then a wait state and a decide state for each
// reference word it examines (at least one), then the finish state: the
// single memory port returns registered read data. A finished result waits
// in an output register; a request that finishes while the previous result
// is still unread stalls in its finish state until that result is taken.
// The reference memory has no clearing pass: an entry read before it was
// written returns arbitrary data.
module rle_frame_difference_encoder #(
	parameter int REF_WORDS    = 65536,
	parameter int HEADER_BYTES = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // packed_word
	input  logic         s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	// changed, new_block, line[11:0], column[11:0], word_out[31:0],
	// block_total[23:0], byte_total[31:0], zero_count_error, pad
	output logic [119:0] m_tdata,
	output logic         m_tlast,   // frame_end
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [12:0]  cfg_data
);
	import rfde_pkg::*;

	rfde_cmd_t  cmd;
	rfde_stat_t stat;
	logic       busy;
	logic [115:0] od;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = busy;
	assign m_tdata   = {5'b0, od[115], od[113:0]};
	assign m_tlast   = od[114];

	rfde_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.out_busy(busy), .m_tready(m_tready), .stat(stat), .cmd(cmd)
	);

	rfde_dpath #(.REF_WORDS(REF_WORDS), .HEADER_BYTES(HEADER_BYTES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(s_tuser), .in_word(s_tdata),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_busy(busy), .out_data(od)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result dropped while stalled");
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
		else $error("new block without change");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the run-length frame difference encoder.
`timescale 1ns / 1ps
// Requests are built by an initial block that also runs its own encoder
// model on every request it queues. This is safe because each queued request
// is accepted in order. The model keeps a copy of both reference banks and
// marks each entry once it is written. A compare request is queued only when
// every reference entry it would read has been written; otherwise the
// request becomes a load request. A clocked driver feeds the queued requests
// to the slave side. A clocked monitor checks every result against the oldest
// prediction. Configuration is written only while the encoder is idle.
module testbench;
	import rfde_pkg::*;

	localparam int REF_DEPTH = 65536;
	localparam int HDR_BYTES = 12;

	typedef struct packed {
		logic        fend;
		logic [4:0]  pad;
		logic        zerr;
		logic [31:0] bytes;
		logic [23:0] blocks;
		logic [31:0] word;
		logic [11:0] column;
		logic [11:0] line;
		logic        new_block;
		logic        changed;
	} delta_t;

	typedef struct {
		logic        cmd;
		logic [31:0] word;
	} run_req_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [12:0]  cfg_data;

	rle_frame_difference_encoder i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Requests waiting for the driver, and the deltas still expected back.
	run_req_t run_queue[$];
	delta_t   delta_queue[$];
	int       fail_count;
	int       send_idle;
	int       recv_idle;
	int       delta_seen;
	int       stall_left;

	// Encoder model state.
	logic [31:0] ref_mem  [0:1][0:REF_DEPTH-1];
	bit          ref_valid[0:1][0:REF_DEPTH-1];
	logic        cur_bank;
	logic [15:0] rd_idx;
	logic [15:0] wr_idx;
	int          gap;
	logic [11:0] row_cnt;
	int          col_cnt;
	logic        in_block;
	logic [23:0] block_cnt;
	logic [31:0] byte_cnt;
	logic [12:0] width_reg;
	logic [12:0] height_reg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int run_len(input logic [31:0] w);
		return (w[7:0] == 8'd0) ? 1 : int'(w[7:0]);
	endfunction

	function automatic int size_limit(input logic [12:0] v);
		if (v == 13'd0) return 1;
		if (v > 13'd4096) return 4096;
		return int'(v);
	endfunction

	// Returns 1 when a compare of w reads only reference entries already written.
	function automatic bit compare_safe(input logic [31:0] w);
		logic [15:0] idx;
		int          g;
		int          n;
		idx = rd_idx;
		g = gap;
		if (!ref_valid[cur_bank][idx]) return 0;
		if (g == 0 && ref_mem[cur_bank][idx] == w) return 1;
		n = 0;
		while (g <= 0) begin
			if (!ref_valid[cur_bank][idx] || n > 600) return 0;
			g += run_len(ref_mem[cur_bank][idx]);
			idx++;
			n++;
		end
		return 1;
	endfunction

	// Applies one request to the model and queues the delta it must produce.
	task automatic encode_run(input logic cmd_in, input logic [31:0] w);
		delta_t      d;
		logic [31:0] left;
		int          wlen;
		int          adv;
		bit          zero;
		bit          chg;
		bit          opened;
		logic [32:0] sum;
		wlen = run_len(w);
		zero = (w[7:0] == 8'd0);
		adv = wlen;
		chg = 0;
		opened = 0;
		d = '0;
		d.line = row_cnt;
		d.column = col_cnt[11:0];
		if (cmd_in == CMD_COMPARE) begin
			left = ref_mem[cur_bank][rd_idx];
			if (gap == 0 && left == w) begin
				// Runs line up and the word repeats: both streams step one word.
				adv = run_len(left);
				if (left[7:0] == 8'd0) zero = 1;
				rd_idx++;
				in_block = 0;
			end else begin
				// Walk reference runs until the reference is ahead of the new word.
				while (gap <= 0) begin
					left = ref_mem[cur_bank][rd_idx];
					rd_idx++;
					if (left[7:0] == 8'd0) zero = 1;
					gap += run_len(left);
				end
				gap -= wlen;
				if (gap != 0 || left != w) begin
					chg = 1;
					if (!in_block) begin
						opened = 1;
						in_block = 1;
					end
				end else begin
					in_block = 0;
				end
			end
			if (chg) begin
				sum = {1'b0, byte_cnt} + 33'd4;
				if (opened) begin
					if (block_cnt != 24'hffffff) block_cnt++;
					sum += 33'(HDR_BYTES);
				end
				byte_cnt = sum[32] ? 32'hffffffff : sum[31:0];
			end
		end
		ref_mem[~cur_bank][wr_idx] = w;
		ref_valid[~cur_bank][wr_idx] = 1;
		wr_idx++;
		d.changed = chg;
		d.new_block = opened;
		d.word = w;
		d.blocks = block_cnt;
		d.bytes = byte_cnt;
		col_cnt += adv;
		if (col_cnt >= size_limit(width_reg)) begin
			col_cnt = 0;
			gap = 0;
			in_block = 0;
			row_cnt++;
			// A wrap to zero means 4096 rows, which ends any frame.
			if (row_cnt == 12'd0 || int'(row_cnt) >= size_limit(height_reg)) begin
				d.fend = 1;
				row_cnt = '0;
				cur_bank = ~cur_bank;
				rd_idx = '0;
				wr_idx = '0;
				block_cnt = '0;
				byte_cnt = '0;
			end
		end
		d.zerr = zero;
		delta_queue.insert(delta_queue.size(), d);
	endtask

	// Queues one request; a compare that would touch unwritten entries becomes a load.
	task automatic queue_run(input logic cmd_in, input logic [31:0] w);
		run_req_t r;
		r.cmd = (cmd_in == CMD_COMPARE && !compare_safe(w)) ? CMD_LOAD : cmd_in;
		r.word = w;
		encode_run(r.cmd, r.word);
		run_queue.insert(run_queue.size(), r);
	endtask

	// Random requests, mostly repeats or small edits of the reference run at
	// the read position so that long matching stretches and misalignment occur.
	task automatic queue_random(input int n, input int max_len);
		logic [31:0] w;
		logic [31:0] base;
		int          pick;
		repeat (n) begin
			base = ref_mem[cur_bank][rd_idx];
			pick = $urandom_range(99);
			w = {24'($urandom()), 8'($urandom_range(1, max_len))};
			if (ref_valid[cur_bank][rd_idx]) begin
				if (pick < 55) w = base;
				else if (pick < 70) w = {w[31:8], base[7:0]};
				else if (pick < 82) w = {base[31:8], w[7:0]};
			end
			if ($urandom_range(99) < 6) w[7:0] = 8'd0;
			else if ($urandom_range(99) < 3) w[7:0] = 8'hff;
			queue_run(($urandom_range(99) < 10) ? CMD_LOAD : CMD_COMPARE, w);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [12:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FRAME_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	task automatic wait_idle();
		wait (run_queue.size() == 0 && delta_queue.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_phase(input logic [12:0] w, input logic [12:0] h, input int s_idle,
			input int r_idle, input int n, input int max_len);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		send_idle = s_idle;
		recv_idle = r_idle;
		queue_random(n, max_len);
		wait_idle();
	endtask

	// Driver: a request stays on the bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) void'(run_queue.pop_front());
			if (run_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= run_queue[0].word;
				s_tuser <= run_queue[0].cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Monitor: checks each delta, and once holds the receiver off for a long
	// stretch while the driver keeps offering requests.
	always @(posedge clk or negedge arst_n) begin
		delta_t act;
		delta_t exp_d;
		if (!arst_n) begin
			m_tready <= 1'b0;
			delta_seen <= 0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				act = {m_tlast, m_tdata};
				if (delta_queue.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
					fail_count++;
				end else begin
					exp_d = delta_queue.pop_front();
					check_field("changed", 32'(exp_d.changed), 32'(act.changed));
					check_field("new_block", 32'(exp_d.new_block), 32'(act.new_block));
					check_field("line", 32'(exp_d.line), 32'(act.line));
					check_field("column", 32'(exp_d.column), 32'(act.column));
					check_field("word_out", exp_d.word, act.word);
					check_field("block_total", 32'(exp_d.blocks), 32'(act.blocks));
					check_field("byte_total", exp_d.bytes, act.bytes);
					check_field("frame_end", 32'(exp_d.fend), 32'(act.fend));
					check_field("zero_count_error", 32'(exp_d.zerr), 32'(act.zerr));
				end
				delta_seen <= delta_seen + 1;
			end
			if (delta_seen == 400 && stall_left == 0) begin
				stall_left <= 300;
				m_tready <= 1'b0;
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				if (stall_left == 1) stall_left <= -1;
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		fail_count = 0;
		send_idle = 26;
		recv_idle = 85;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		cur_bank = 1'b0;
		rd_idx = '0;
		wr_idx = '0;
		gap = 0;
		row_cnt = '0;
		col_cnt = 0;
		in_block = 0;
		block_cnt = '0;
		byte_cnt = '0;
		width_reg = 13'd1920;
		height_reg = 13'd1080;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: an 8 by 2 frame of loads, then compares against it
		// covering equal runs, a changed word, misalignment and zero counts.
		write_reg(CFG_FRAME_WIDTH, 13'd8);
		write_reg(CFG_FRAME_HEIGHT, 13'd2);
		queue_run(CMD_LOAD, 32'h0000_0000);
		queue_run(CMD_LOAD, 32'h1234_5607);
		queue_run(CMD_LOAD, 32'h00ff_0003);
		queue_run(CMD_LOAD, 32'h00ff_0005);
		queue_run(CMD_COMPARE, 32'h0000_0000);
		queue_run(CMD_COMPARE, 32'habcd_ef07);
		queue_run(CMD_COMPARE, 32'h00ff_0004);
		queue_run(CMD_COMPARE, 32'h00ff_0004);
		queue_run(CMD_COMPARE, 32'hffff_ffff);
		queue_run(CMD_COMPARE, 32'h0000_0000);
		queue_run(CMD_LOAD, 32'h5555_5507);
		queue_run(CMD_COMPARE, 32'haaaa_aa02);
		queue_run(CMD_COMPARE, 32'haaaa_aa00);
		queue_run(CMD_COMPARE, 32'hffff_ff05);
		queue_run(CMD_COMPARE, 32'hffff_ffff);
		queue_run(CMD_COMPARE, 32'h0000_0001);
		queue_run(CMD_COMPARE, 32'h0000_0007);
		queue_run(CMD_COMPARE, 32'h8000_0008);
		queue_run(CMD_COMPARE, 32'h7fff_ff08);
		wait_idle();

		// Random part through several frame sizes, the extremes among them.
		run_phase(13'd40, 13'd3, 26, 85, 300, 12);
		run_phase(13'd0, 13'd0, 26, 85, 60, 4);
		run_phase(13'd4096, 13'd4096, 85, 26, 50, 255);
		run_phase(13'd8191, 13'd1, 85, 26, 40, 255);
		run_phase(13'd1, 13'd4, 85, 26, 60, 3);
		run_phase(13'd20, 13'd2, 0, 0, 350, 8);
		run_phase(13'd64, 13'd4, 0, 0, 390, 16);

		repeat (50) @(posedge clk);
		if (fail_count == 0 && delta_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
